>>> rtl/msar_pkg.sv
// Shared types, instruction codes and the decoder for the MIPS subset executor.
package msar_pkg;

    // Default sizing of the register file.
    localparam int NUM_REGS_DEF  = 32;
    localparam int REG_WIDTH_DEF = 16;

    // Stream widths.
    localparam int IN_DATA_W   = 32;
    localparam int IDX_W       = 5;
    localparam int IMM_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    // Primary opcodes.
    localparam logic [5:0] OPC_RTYPE = 6'd0;
    localparam logic [5:0] OPC_ADDI  = 6'd8;
    localparam logic [5:0] OPC_ANDI  = 6'd12;
    localparam logic [5:0] OPC_ORI   = 6'd13;

    // R-type function codes.
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRA = 6'd3;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_NOR = 6'd39;

    // Operation class after decode.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_SLL,
        OP_SRA,
        OP_ADD,
        OP_SUB,
        OP_AND,
        OP_OR,
        OP_NOR,
        OP_ADDI,
        OP_ANDI,
        OP_ORI
    } op_kind_t;

    // Decoded instruction as it travels from the front to the back.
    typedef struct packed {
        op_kind_t           kind;
        logic [IDX_W-1:0]   rs;
        logic [IDX_W-1:0]   rt;
        logic [IDX_W-1:0]   dst;
        logic [IDX_W-1:0]   shamt;
        logic [IMM_W-1:0]   imm;
    } dec_item_t;

    // Split an instruction word into its fields and classify it.
    function automatic dec_item_t decode_word(input logic [IN_DATA_W-1:0] word);
        dec_item_t  item;
        logic [5:0] opc;
        logic [5:0] fn;
        opc        = word[31:26];
        fn         = word[5:0];
        item.rs    = word[25:21];
        item.rt    = word[20:16];
        item.shamt = word[10:6];
        item.imm   = word[15:0];
        item.kind  = OP_NONE;
        item.dst   = word[20:16];
        if (opc == OPC_RTYPE)
        begin
            item.dst = word[15:11];
            unique case (fn)
                FN_SLL:  item.kind = OP_SLL;
                FN_SRA:  item.kind = OP_SRA;
                FN_ADD:  item.kind = OP_ADD;
                FN_SUB:  item.kind = OP_SUB;
                FN_AND:  item.kind = OP_AND;
                FN_OR:   item.kind = OP_OR;
                FN_NOR:  item.kind = OP_NOR;
                default: item.kind = OP_NONE;
            endcase
        end
        else
        begin
            unique case (opc)
                OPC_ADDI: item.kind = OP_ADDI;
                OPC_ANDI: item.kind = OP_ANDI;
                OPC_ORI:  item.kind = OP_ORI;
                default:  item.kind = OP_NONE;
            endcase
        end
        return item;
    endfunction

endpackage

>>> rtl/msar_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module msar_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; returns the old contents on a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/msar_front.sv
// Front end: accepts instruction beats and registers their decoded form.
module msar_front
    import msar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [31:0] instruction_word
    output logic                 dec_valid,
    input  logic                 dec_ready,
    output dec_item_t            dec_item
);

    logic      valid_reg;
    logic      valid_next;
    dec_item_t item_reg;
    logic      take;

    // The stage takes a beat when it is empty or hands its item on this cycle.
    assign s_axis_tready = !valid_reg || dec_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (dec_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Decoded payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= decode_word(s_axis_tdata);
        end
    end

    assign dec_valid = valid_reg;
    assign dec_item  = item_reg;

endmodule

>>> rtl/msar_queue.sv
// Short queue of decoded instructions between the front end and the back end.
module msar_queue
    import msar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dec_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output dec_item_t out_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dec_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> rtl/msar_back.sv
// Back end: reads the register file, executes, writes back and holds the result beat.
module msar_back
    import msar_pkg::*;
#(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int REG_WIDTH = REG_WIDTH_DEF,
    localparam int OUT_W    = ((1 + IDX_W + REG_WIDTH + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  dec_item_t        q_item,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata   // [0] write_done, [5:1] dest_index, then dest_value
);

    localparam int AW = $clog2(NUM_REGS);

    // Execute stage.
    logic             e_valid_reg;
    logic             e_valid_next;
    dec_item_t        e_item_reg;
    logic             e_leave;
    logic             pop;

    // Register file: two RAM copies, one per read port.
    logic [REG_WIDTH-1:0] ram_a;
    logic [REG_WIDTH-1:0] ram_b;
    logic [NUM_REGS-1:0]  written_reg;
    logic [NUM_REGS-1:0]  written_next;

    // Most recent write, to cover a read issued in the same cycle as that write.
    logic                 fwd_valid_reg;
    logic [AW-1:0]        fwd_idx_reg;
    logic [REG_WIDTH-1:0] fwd_val_reg;

    // Operands and result.
    logic                 rs_ok;
    logic                 rt_ok;
    logic                 dst_ok;
    logic [AW-1:0]        rs_a;
    logic [AW-1:0]        rt_a;
    logic [AW-1:0]        dst_a;
    logic [REG_WIDTH-1:0] op_a;
    logic [REG_WIDTH-1:0] op_b;
    logic [REG_WIDTH-1:0] imm_sx;
    logic [REG_WIDTH-1:0] imm_zx;
    logic [REG_WIDTH-1:0] res;
    logic                 wr;

    // Output register.
    logic                 o_valid_reg;
    logic                 o_valid_next;
    logic                 o_done_reg;
    logic [IDX_W-1:0]     o_idx_reg;
    logic [REG_WIDTH-1:0] o_val_reg;

    // Stage handshakes.
    assign e_leave = e_valid_reg && (!o_valid_reg || m_axis_tready);
    assign q_ready = !e_valid_reg || e_leave;
    assign pop     = q_valid && q_ready;

    always_comb
    begin
        e_valid_next = e_valid_reg;
        if (pop)
        begin
            e_valid_next = 1'b1;
        end
        else if (e_leave)
        begin
            e_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            e_item_reg <= q_item;
        end
    end

    // Index range checks and RAM addresses.
    assign rs_ok  = ({1'b0, e_item_reg.rs}  < (IDX_W + 1)'(NUM_REGS));
    assign rt_ok  = ({1'b0, e_item_reg.rt}  < (IDX_W + 1)'(NUM_REGS));
    assign dst_ok = ({1'b0, e_item_reg.dst} < (IDX_W + 1)'(NUM_REGS));
    assign rs_a   = e_item_reg.rs[AW-1:0];
    assign rt_a   = e_item_reg.rt[AW-1:0];
    assign dst_a  = e_item_reg.dst[AW-1:0];

    msar_ram #(
        .WIDTH (REG_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_ram_a (
        .clk   (clk),
        .we    (e_leave && wr),
        .waddr (dst_a),
        .wdata (res),
        .re    (pop),
        .raddr (q_item.rs[AW-1:0]),
        .rdata (ram_a)
    );

    msar_ram #(
        .WIDTH (REG_WIDTH),
        .DEPTH (NUM_REGS)
    ) u_ram_b (
        .clk   (clk),
        .we    (e_leave && wr),
        .waddr (dst_a),
        .wdata (res),
        .re    (pop),
        .raddr (q_item.rt[AW-1:0]),
        .rdata (ram_b)
    );

    // Operand select: out of range or never written reads as zero.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (rs_ok)
        begin
            if (fwd_valid_reg && (fwd_idx_reg == rs_a))
            begin
                op_a = fwd_val_reg;
            end
            else if (written_reg[rs_a])
            begin
                op_a = ram_a;
            end
        end
        if (rt_ok)
        begin
            if (fwd_valid_reg && (fwd_idx_reg == rt_a))
            begin
                op_b = fwd_val_reg;
            end
            else if (written_reg[rt_a])
            begin
                op_b = ram_b;
            end
        end
    end

    // Immediate forms: sign-extended for addi, zero-extended for the logic ops.
    assign imm_sx = REG_WIDTH'({{(32 - IMM_W){e_item_reg.imm[IMM_W-1]}}, e_item_reg.imm});
    assign imm_zx = REG_WIDTH'({{(32 - IMM_W){1'b0}}, e_item_reg.imm});

    // ALU.
    always_comb
    begin
        unique case (e_item_reg.kind)
            OP_SLL:  res = op_b << e_item_reg.shamt;
            OP_SRA:  res = $signed(op_b) >>> e_item_reg.shamt;
            OP_ADD:  res = op_a + op_b;
            OP_SUB:  res = op_a - op_b;
            OP_AND:  res = op_a & op_b;
            OP_OR:   res = op_a | op_b;
            OP_NOR:  res = ~(op_a | op_b);
            OP_ADDI: res = op_a + imm_sx;
            OP_ANDI: res = op_a & imm_zx;
            OP_ORI:  res = op_a | imm_zx;
            default: res = '0;
        endcase
    end

    assign wr = (e_item_reg.kind != OP_NONE) && dst_ok;

    // Written flags stand in for the zero reset of the register file.
    always_comb
    begin
        written_next = written_reg;
        if (e_leave && wr)
        begin
            written_next[dst_a] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            written_reg <= written_next;
            if (e_leave && wr)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_leave && wr)
        begin
            fwd_idx_reg <= dst_a;
            fwd_val_reg <= res;
        end
    end

    // Output beat register.
    always_comb
    begin
        o_valid_next = o_valid_reg;
        if (e_leave)
        begin
            o_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_leave)
        begin
            o_done_reg <= wr;
            o_idx_reg  <= wr ? e_item_reg.dst : '0;
            o_val_reg  <= wr ? res : '0;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = OUT_W'({o_val_reg, o_idx_reg, o_done_reg});

endmodule

>>> rtl/mips_subset_alu_regfile.sv
// Path: front register, queue, execute register, output register. Throughput: one
// instruction per cycle unless the output stalls; the back end resolves a dependence
// on the previous instruction through a one-entry write bypass, so no bubble is needed.
// Reset: rst_n is asynchronous and active low; every register reads as zero afterwards,
// tracked by per-register written flags, so no clearing pass is run.
module mips_subset_alu_regfile
    import msar_pkg::*;
#(
    parameter int NUM_REGS  = NUM_REGS_DEF,
    parameter int REG_WIDTH = REG_WIDTH_DEF,
    localparam int OUT_W    = ((1 + IDX_W + REG_WIDTH + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // [31:0] instruction_word
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata    // [0] write_done, [5:1] dest_index,
                                                 // then dest_value, zero padded
);

    logic      dec_valid;
    logic      dec_ready;
    dec_item_t dec_item;
    logic      q_valid;
    logic      q_ready;
    dec_item_t q_item;

    // Accept and decode.
    msar_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .dec_valid     (dec_valid),
        .dec_ready     (dec_ready),
        .dec_item      (dec_item)
    );

    // Decoupling queue.
    msar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_item   (dec_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Execute and write back.
    msar_back #(
        .NUM_REGS  (NUM_REGS),
        .REG_WIDTH (REG_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> sim/mips_subset_alu_regfile_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the MIPS subset executor: directed and random instruction streams.
module mips_subset_alu_regfile_test;
    import msar_pkg::*;

    localparam int OUT_W         = ((1 + IDX_W + REG_WIDTH_DEF + 7) / 8) * 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 12;

    // One register write as the block reports it.
    typedef struct packed {
        logic                     done;
        logic [IDX_W-1:0]         idx;
        logic [REG_WIDTH_DEF-1:0] value;
    } reg_write_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;   // [31:0] instruction_word
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // [0] write_done, [5:1] dest_index,
                                                // then dest_value, zero padded

    logic [REG_WIDTH_DEF-1:0] shadow_regs [NUM_REGS_DEF];
    logic [IN_DATA_W-1:0]     instr_pending [$];
    reg_write_t               writes_expected [$];
    logic                     instr_taken = 1'b0;
    logic                     calm        = 1'b0;
    int                       src_gap     = 0;
    int                       sink_gap    = 0;
    int                       idle_cycles = 0;
    int                       fault_count = 0;

    mips_subset_alu_regfile dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Executes one instruction on the shadow register file and returns the write it causes.
    function automatic reg_write_t apply_instruction(input logic [IN_DATA_W-1:0] word);
        logic [5:0]                      opc;
        logic [5:0]                      fn;
        logic [IDX_W-1:0]                rs;
        logic [IDX_W-1:0]                rt;
        logic [IDX_W-1:0]                dst;
        logic [IDX_W-1:0]                sh;
        logic [REG_WIDTH_DEF-1:0]        a;
        logic [REG_WIDTH_DEF-1:0]        b;
        logic [REG_WIDTH_DEF-1:0]        res;
        logic [IMM_W-1:0]                imm;
        logic signed [REG_WIDTH_DEF-1:0] b_signed;
        logic                            writes;
        reg_write_t                      wr;
        opc      = word[31:26];
        fn       = word[5:0];
        rs       = word[25:21];
        rt       = word[20:16];
        sh       = word[10:6];
        imm      = word[15:0];
        a        = (rs < NUM_REGS_DEF) ? shadow_regs[rs] : '0;
        b        = (rt < NUM_REGS_DEF) ? shadow_regs[rt] : '0;
        b_signed = b;
        res      = '0;
        writes   = 1'b1;
        dst      = rt;
        wr       = '0;
        if (opc == OPC_RTYPE)
        begin
            dst = word[15:11];
            case (fn)
                FN_SLL:
                begin
                    if (sh >= REG_WIDTH_DEF)
                        res = '0;
                    else
                        res = b << sh;
                end
                FN_SRA:
                begin
                    // Arithmetic shift; large amounts leave only copies of the sign bit.
                    if (sh >= REG_WIDTH_DEF)
                        res = {REG_WIDTH_DEF{b[REG_WIDTH_DEF-1]}};
                    else
                        res = b_signed >>> sh;
                end
                FN_ADD:  res = a + b;
                FN_SUB:  res = a - b;
                FN_AND:  res = a & b;
                FN_OR:   res = a | b;
                FN_NOR:  res = ~(a | b);
                default: writes = 1'b0;
            endcase
        end
        else
        begin
            // The registers are as wide as the immediate, so sign and zero extension
            // both leave its bits as they are.
            case (opc)
                OPC_ADDI: res = a + imm;
                OPC_ANDI: res = a & imm;
                OPC_ORI:  res = a | imm;
                default:  writes = 1'b0;
            endcase
        end
        if (writes && dst < NUM_REGS_DEF)
        begin
            shadow_regs[dst] = res;
            wr.done          = 1'b1;
            wr.idx           = dst;
            wr.value         = res;
        end
        return wr;
    endfunction

    function automatic logic [IN_DATA_W-1:0] r_word(input logic [5:0] fn,
                                                    input logic [IDX_W-1:0] rs,
                                                    input logic [IDX_W-1:0] rt,
                                                    input logic [IDX_W-1:0] rd,
                                                    input logic [IDX_W-1:0] sh);
        return {OPC_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [IN_DATA_W-1:0] i_word(input logic [5:0] opc,
                                                    input logic [IDX_W-1:0] rs,
                                                    input logic [IDX_W-1:0] rt,
                                                    input logic [IMM_W-1:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    // Half the picks come from a few low registers so that results feed each other.
    function automatic logic [IDX_W-1:0] pick_reg();
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 3));
        return IDX_W'($urandom_range(0, NUM_REGS_DEF - 1));
    endfunction

    // Mostly supported instructions with random operands; the rest is unknown codes and noise.
    function automatic logic [IN_DATA_W-1:0] random_instruction();
        logic [IDX_W-1:0] rs;
        logic [IDX_W-1:0] rt;
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] sh;
        logic [IMM_W-1:0] imm;
        int               pick;
        rs   = pick_reg();
        rt   = pick_reg();
        rd   = pick_reg();
        sh   = IDX_W'($urandom_range(0, 31));
        case ($urandom_range(0, 7))
            0:       imm = 16'h0000;
            1:       imm = 16'hFFFF;
            2:       imm = 16'h8000;
            3:       imm = 16'h7FFF;
            default: imm = IMM_W'($urandom());
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return $urandom();
        if (pick < 14)
            return r_word(6'($urandom()), rs, rt, rd, sh);
        case ($urandom_range(0, 9))
            0:       return r_word(FN_SLL, rs, rt, rd, sh);
            1:       return r_word(FN_SRA, rs, rt, rd, sh);
            2:       return r_word(FN_ADD, rs, rt, rd, sh);
            3:       return r_word(FN_SUB, rs, rt, rd, sh);
            4:       return r_word(FN_AND, rs, rt, rd, sh);
            5:       return r_word(FN_OR, rs, rt, rd, sh);
            6:       return r_word(FN_NOR, rs, rt, rd, sh);
            7:       return i_word(OPC_ADDI, rs, rt, imm);
            8:       return i_word(OPC_ANDI, rs, rt, imm);
            default: return i_word(OPC_ORI, rs, rt, imm);
        endcase
    endfunction

    // Blocks until every queued instruction is taken and every write has come back.
    task automatic wait_drained();
        while (instr_pending.size() != 0 || s_axis_tvalid || writes_expected.size() != 0)
            @(posedge clk);
    endtask

    // Clock generation.
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Stimulus: directed cases, then random phases separated by full drains.
    initial
    begin
        for (int i = 0; i < NUM_REGS_DEF; i++)
            shadow_regs[i] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Immediate extremes and sign extension.
        instr_pending.push_back(i_word(OPC_ADDI, 5'd0, 5'd1, 16'h7FFF));
        instr_pending.push_back(i_word(OPC_ADDI, 5'd0, 5'd2, 16'h8000));
        instr_pending.push_back(i_word(OPC_ADDI, 5'd0, 5'd3, 16'hFFFF));
        instr_pending.push_back(i_word(OPC_ORI, 5'd0, 5'd4, 16'hFFFF));
        instr_pending.push_back(i_word(OPC_ANDI, 5'd4, 5'd5, 16'h00FF));
        // Arithmetic wrap and the logic operations.
        instr_pending.push_back(r_word(FN_ADD, 5'd1, 5'd1, 5'd6, 5'd0));
        instr_pending.push_back(r_word(FN_ADD, 5'd3, 5'd3, 5'd7, 5'd0));
        instr_pending.push_back(r_word(FN_SUB, 5'd0, 5'd3, 5'd8, 5'd0));
        instr_pending.push_back(r_word(FN_SUB, 5'd2, 5'd1, 5'd9, 5'd0));
        instr_pending.push_back(r_word(FN_AND, 5'd3, 5'd1, 5'd10, 5'd0));
        instr_pending.push_back(r_word(FN_OR, 5'd1, 5'd2, 5'd11, 5'd0));
        instr_pending.push_back(r_word(FN_NOR, 5'd0, 5'd0, 5'd12, 5'd0));
        // Shifts by zero, by the top bit, by the register width and beyond.
        instr_pending.push_back(r_word(FN_SLL, 5'd0, 5'd3, 5'd13, 5'd0));
        instr_pending.push_back(r_word(FN_SLL, 5'd0, 5'd1, 5'd14, 5'd15));
        instr_pending.push_back(r_word(FN_SLL, 5'd0, 5'd3, 5'd15, 5'd16));
        instr_pending.push_back(r_word(FN_SLL, 5'd0, 5'd3, 5'd16, 5'd31));
        instr_pending.push_back(r_word(FN_SRA, 5'd0, 5'd2, 5'd17, 5'd15));
        instr_pending.push_back(r_word(FN_SRA, 5'd0, 5'd2, 5'd18, 5'd16));
        instr_pending.push_back(r_word(FN_SRA, 5'd0, 5'd1, 5'd19, 5'd31));
        instr_pending.push_back(r_word(FN_SRA, 5'd0, 5'd2, 5'd20, 5'd0));
        // Register zero is writable and then read back.
        instr_pending.push_back(i_word(OPC_ADDI, 5'd0, 5'd0, 16'd5));
        instr_pending.push_back(r_word(FN_ADD, 5'd0, 5'd0, 5'd31, 5'd0));
        // Unknown function and opcode codes, and the all-ones word.
        instr_pending.push_back(r_word(6'd1, 5'd1, 5'd2, 5'd21, 5'd0));
        instr_pending.push_back(i_word(6'd63, 5'd1, 5'd22, 16'h1234));
        instr_pending.push_back(32'hFFFF_FFFF);
        wait_drained();

        repeat (1000) instr_pending.push_back(random_instruction());
        wait_drained();
        repeat (500) instr_pending.push_back(random_instruction());
        wait_drained();

        // Final stretch runs at full rate on both sides.
        calm = 1'b1;
        repeat (250) instr_pending.push_back(random_instruction());
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Instruction driver: holds each beat until taken, with random idle bursts.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !instr_taken)
            begin
                s_axis_tvalid <= 1'b1;
            end
            else if (src_gap > 0)
            begin
                src_gap       <= src_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (instr_pending.size() > 0 && !calm && $urandom_range(0, 7) == 0)
            begin
                src_gap       <= $urandom_range(0, 4);
                s_axis_tvalid <= 1'b0;
            end
            else if (instr_pending.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= instr_pending.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Accepted instruction beats update the shadow file and queue the expected write.
    always @(posedge clk)
    begin
        instr_taken <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            writes_expected.push_back(apply_instruction(s_axis_tdata));
    end

    // Result ready: random stall bursts except in the final stretch.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_gap > 0)
            begin
                sink_gap      <= sink_gap - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_gap      <= $urandom_range(0, 4);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Result monitor: compares each beat field by field with the oldest expected write.
    always @(posedge clk)
    begin
        reg_write_t got;
        reg_write_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.done  = m_axis_tdata[0];
            got.idx   = m_axis_tdata[IDX_W:1];
            got.value = m_axis_tdata[IDX_W+1 +: REG_WIDTH_DEF];
            if (writes_expected.size() == 0)
            begin
                fault_count <= fault_count + 1;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = writes_expected.pop_front();
                if (got !== want)
                begin
                    fault_count <= fault_count + 1;
                    $display("%0t: done exp %0d act %0d, index exp %0d act %0d, value exp %h act %h",
                             $time, want.done, got.done, want.idx, got.idx,
                             want.value, got.value);
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
